### rtl/pa_pkg.sv
// ----------------------------------------------------------------------------
// pa_pkg
// Shared types, codes and helpers of the pushdown automaton recognizer.
// ----------------------------------------------------------------------------
`default_nettype none

package pa_pkg;

    // Fixed geometry of the item fields
    localparam int SYMBOL_COUNT = 16;
    localparam int MAX_PUSH     = 4;

    // Input commands
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_SYM  = 2'd1;
    localparam logic [1:0] CMD_END  = 2'd2;
    localparam logic [1:0] CMD_NOP  = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_ACCEPT   = 3'd0;
    localparam logic [2:0] ST_REJECT   = 3'd1;
    localparam logic [2:0] ST_ILLEGAL  = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_LIMIT    = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_START_STATE  = 3'd0;
    localparam logic [2:0] CFG_START_SYMBOL = 3'd1;
    localparam logic [2:0] CFG_ACCEPT       = 3'd2;
    localparam logic [2:0] CFG_ALLOWED      = 3'd3;
    localparam logic [2:0] CFG_ENTRY_COUNT  = 3'd4;
    localparam logic [2:0] CFG_MOVE_LIMIT   = 3'd5;

    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_SYM,
        KIND_END
    } pa_kind_t;

    typedef struct packed {
        logic [3:0]  from_state;
        logic [3:0]  read_symbol;
        logic        read_epsilon;
        logic [3:0]  need_top;
        logic [3:0]  to_state;
        logic [2:0]  push_count;
        logic [15:0] push_string;
    } pa_entry_t;

    typedef struct packed {
        pa_kind_t   kind;
        logic [5:0] entry_index;
        pa_entry_t  entry;
        logic [3:0] data_symbol;
        logic       last_symbol;
        logic       illegal;
    } pa_item_t;

    typedef struct packed {
        logic [3:0]  start_state;
        logic [3:0]  start_stack_symbol;
        logic [15:0] accept_states;
        logic [6:0]  entry_count;
        logic [15:0] move_limit;
    } pa_cfg_t;

    // Limit the push length to the widest string an entry carries
    function automatic logic [2:0] clamp_push(input logic [2:0] cnt);
        if (int'(cnt) > MAX_PUSH) begin
            return 3'(MAX_PUSH);
        end
        return cnt;
    endfunction

    // Pick symbol i of a push string
    function automatic logic [3:0] push_sym(input logic [15:0] str, input logic [2:0] i);
        return 4'(str >> {i[1:0], 2'b00});
    endfunction

endpackage

`default_nettype wire

### rtl/pa_front.sv
// ----------------------------------------------------------------------------
// pa_front
// Accepts input words, classifies them and queues them for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module pa_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        in_command,
    input  wire pa_pkg::pa_entry_t in_entry,
    input  wire logic [5:0]        in_entry_index,
    input  wire logic [3:0]        in_data_symbol,
    input  wire logic              in_last,
    input  wire logic [15:0]       symbol_allowed,
    output logic                   q_valid,
    input  wire logic              q_ready,
    output pa_pkg::pa_item_t       q_item
);

    pa_pkg::pa_item_t slot_reg [2];
    logic             wptr_reg, wptr_next;
    logic             rptr_reg, rptr_next;
    logic [1:0]       fill_reg, fill_next;
    pa_pkg::pa_item_t item;
    logic             push, pop, legal;

    // Classify the incoming word
    always_comb begin
        legal = (int'(in_data_symbol) < pa_pkg::SYMBOL_COUNT) && symbol_allowed[in_data_symbol];
        item.entry_index = in_entry_index;
        item.entry       = in_entry;
        item.data_symbol = in_data_symbol;
        item.last_symbol = in_last;
        item.illegal     = !legal;
        unique case (in_command)
            pa_pkg::CMD_LOAD: item.kind = pa_pkg::KIND_LOAD;
            pa_pkg::CMD_SYM:  item.kind = pa_pkg::KIND_SYM;
            default:          item.kind = pa_pkg::KIND_END;
        endcase
    end

    assign in_ready = (fill_reg != 2'd2);
    assign push     = in_valid && in_ready && (in_command != pa_pkg::CMD_NOP);
    assign q_valid  = (fill_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_item   = slot_reg[rptr_reg];

    // Advance pointers and fill level
    always_comb begin
        wptr_next = push ? !wptr_reg : wptr_reg;
        rptr_next = pop ? !rptr_reg : rptr_reg;
        fill_next = 2'(fill_reg + 2'(push) - 2'(pop));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    // Hold queued words
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= item;
        end
    end

endmodule

`default_nettype wire

### rtl/pa_engine.sv
// ----------------------------------------------------------------------------
// pa_engine
// Runs queued words: table loads, automaton moves and result reporting.
// ----------------------------------------------------------------------------
`default_nettype none

module pa_engine #(
    parameter int TABLE_ENTRIES = 64,
    parameter int STACK_DEPTH   = 256
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire pa_pkg::pa_cfg_t  cfg,
    input  wire logic             q_valid,
    output logic                  q_ready,
    input  wire pa_pkg::pa_item_t q_item,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [2:0]            out_status,
    output logic [3:0]            out_final_state,
    output logic [8:0]            out_stack_level
);

    localparam int TAW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SW  = $clog2(TABLE_ENTRIES + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int HW  = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        E_IDLE, E_OPEN, E_DISPATCH, E_CHECK, E_SCAN, E_PUSH, E_TOP, E_NEXT,
        E_AFTER, E_FINISH, E_RESULT
    } eng_state_t;

    eng_state_t        fsm_reg, fsm_next;
    logic [3:0]        auto_reg, auto_next;
    logic [HW-1:0]     height_reg, height_next;
    logic [3:0]        top_reg, top_next;
    logic [2:0]        status_reg, status_next;
    logic              open_reg, open_next;
    logic [15:0]       moves_reg, moves_next;
    logic              ending_reg, ending_next;
    pa_pkg::pa_item_t  cur_reg, cur_next;
    logic [SW-1:0]     scan_reg, scan_next;
    logic              pend_reg, pend_next;
    pa_pkg::pa_entry_t ent_reg, ent_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [2:0]        k_reg, k_next;
    logic              oval_reg, oval_next;
    logic [2:0]        ostat_reg, ostat_next;
    logic [3:0]        ofin_reg, ofin_next;
    logic [8:0]        olvl_reg, olvl_next;

    pa_pkg::pa_entry_t table_mem [TABLE_ENTRIES];
    logic [3:0]        stack_mem [STACK_DEPTH];
    pa_pkg::pa_entry_t tab_q;
    logic [3:0]        stk_q;

    logic              tab_we, tab_re;
    logic [TAW-1:0]    tab_waddr, tab_raddr;
    logic              stk_we, stk_re;
    logic [SAW-1:0]    stk_waddr, stk_raddr;
    logic [3:0]        stk_wdata;

    logic [15:0]       limit;
    logic [SW-1:0]     n_eff;
    logic              hit;
    logic [2:0]        cnt_hit;
    logic [HW:0]       grow;
    logic [31:0]       lvl_wide;
    logic [3:0]        push_val;

    assign q_ready         = (fsm_reg == E_IDLE);
    assign out_valid       = oval_reg;
    assign out_status      = ostat_reg;
    assign out_final_state = ofin_reg;
    assign out_stack_level = olvl_reg;

    // Limits and the match against the entry just read
    always_comb begin
        limit = (cfg.move_limit == 16'd0) ? 16'd1 : cfg.move_limit;
        if (int'(cfg.entry_count) > TABLE_ENTRIES) begin
            n_eff = SW'(TABLE_ENTRIES);
        end else begin
            n_eff = SW'(cfg.entry_count);
        end
        hit = pend_reg && (tab_q.from_state == auto_reg) && (tab_q.need_top == top_reg) &&
              (tab_q.read_epsilon ||
               (!ending_reg && (tab_q.read_symbol == cur_reg.data_symbol)));
        cnt_hit  = pa_pkg::clamp_push(tab_q.push_count);
        grow     = (HW+1)'(height_reg) + (HW+1)'(cnt_hit);
        lvl_wide = 32'(height_reg);
        push_val = pa_pkg::push_sym(ent_reg.push_string, 3'(cnt_reg - 3'd1 - k_reg));
    end

    // Sequence each word
    always_comb begin
        fsm_next    = fsm_reg;
        auto_next   = auto_reg;
        height_next = height_reg;
        top_next    = top_reg;
        status_next = status_reg;
        open_next   = open_reg;
        moves_next  = moves_reg;
        ending_next = ending_reg;
        cur_next    = cur_reg;
        scan_next   = scan_reg;
        pend_next   = pend_reg;
        ent_next    = ent_reg;
        cnt_next    = cnt_reg;
        k_next      = k_reg;
        oval_next   = oval_reg && !out_ready;
        ostat_next  = ostat_reg;
        ofin_next   = ofin_reg;
        olvl_next   = olvl_reg;
        tab_we      = 1'b0;
        tab_waddr   = TAW'(q_item.entry_index);
        tab_re      = 1'b0;
        tab_raddr   = scan_reg[TAW-1:0];
        stk_we      = 1'b0;
        stk_waddr   = height_reg[SAW-1:0];
        stk_wdata   = push_val;
        stk_re      = 1'b0;
        stk_raddr   = SAW'(height_reg - HW'(2));

        unique case (fsm_reg)
            E_IDLE: begin
                if (q_valid) begin
                    cur_next = q_item;
                    unique case (q_item.kind)
                        pa_pkg::KIND_LOAD: begin
                            tab_we = (int'(q_item.entry_index) < TABLE_ENTRIES);
                        end
                        default: begin
                            fsm_next = open_reg ? E_DISPATCH : E_OPEN;
                        end
                    endcase
                end
            end
            E_OPEN: begin
                stk_we      = 1'b1;
                stk_waddr   = SAW'(0);
                stk_wdata   = cfg.start_stack_symbol;
                auto_next   = cfg.start_state;
                height_next = HW'(1);
                top_next    = cfg.start_stack_symbol;
                status_next = pa_pkg::ST_ACCEPT;
                open_next   = 1'b1;
                fsm_next    = E_DISPATCH;
            end
            E_DISPATCH: begin
                if (cur_reg.kind == pa_pkg::KIND_SYM) begin
                    if (cur_reg.illegal) begin
                        status_next = pa_pkg::ST_ILLEGAL;
                        fsm_next    = E_AFTER;
                    end else if (status_reg == pa_pkg::ST_ACCEPT) begin
                        moves_next  = 16'd0;
                        ending_next = 1'b0;
                        fsm_next    = E_CHECK;
                    end else begin
                        fsm_next = E_AFTER;
                    end
                end else begin
                    fsm_next = E_FINISH;
                end
            end
            E_CHECK: begin
                scan_next = '0;
                pend_next = 1'b0;
                if (height_reg == HW'(0)) begin
                    if (ending_reg) begin
                        fsm_next = E_RESULT;
                    end else begin
                        status_next = pa_pkg::ST_REJECT;
                        fsm_next    = E_AFTER;
                    end
                end else begin
                    fsm_next = E_SCAN;
                end
            end
            E_SCAN: begin
                priority if (hit) begin
                    ent_next  = tab_q;
                    pend_next = 1'b0;
                    if (moves_reg >= limit) begin
                        status_next = pa_pkg::ST_LIMIT;
                        fsm_next    = ending_reg ? E_RESULT : E_AFTER;
                    end else if (grow > (HW+1)'(STACK_DEPTH + 1)) begin
                        status_next = pa_pkg::ST_OVERFLOW;
                        fsm_next    = ending_reg ? E_RESULT : E_AFTER;
                    end else begin
                        height_next = HW'(height_reg - HW'(1));
                        auto_next   = tab_q.to_state;
                        moves_next  = 16'(moves_reg + 16'd1);
                        cnt_next    = cnt_hit;
                        k_next      = 3'd0;
                        if (cnt_hit != 3'd0) begin
                            fsm_next = E_PUSH;
                        end else if (height_reg == HW'(1)) begin
                            fsm_next = E_NEXT;
                        end else begin
                            stk_re   = 1'b1;
                            fsm_next = E_TOP;
                        end
                    end
                end else if (scan_reg < n_eff) begin
                    tab_re    = 1'b1;
                    scan_next = SW'(scan_reg + SW'(1));
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (ending_reg) begin
                        fsm_next = E_RESULT;
                    end else begin
                        status_next = pa_pkg::ST_REJECT;
                        fsm_next    = E_AFTER;
                    end
                end
            end
            E_PUSH: begin
                stk_we      = 1'b1;
                height_next = HW'(height_reg + HW'(1));
                k_next      = 3'(k_reg + 3'd1);
                if (k_reg == 3'(cnt_reg - 3'd1)) begin
                    top_next = push_val;
                    fsm_next = E_NEXT;
                end
            end
            E_TOP: begin
                top_next = stk_q;
                fsm_next = E_NEXT;
            end
            E_NEXT: begin
                if (!ending_reg && !ent_reg.read_epsilon) begin
                    fsm_next = E_AFTER;
                end else begin
                    fsm_next = E_CHECK;
                end
            end
            E_AFTER: begin
                fsm_next = cur_reg.last_symbol ? E_FINISH : E_IDLE;
            end
            E_FINISH: begin
                if (status_reg == pa_pkg::ST_ACCEPT) begin
                    moves_next  = 16'd0;
                    ending_next = 1'b1;
                    fsm_next    = E_CHECK;
                end else begin
                    fsm_next = E_RESULT;
                end
            end
            E_RESULT: begin
                if (!oval_reg || out_ready) begin
                    oval_next = 1'b1;
                    if (status_reg == pa_pkg::ST_ACCEPT) begin
                        ostat_next = cfg.accept_states[auto_reg] ? pa_pkg::ST_ACCEPT
                                                                 : pa_pkg::ST_REJECT;
                    end else begin
                        ostat_next = status_reg;
                    end
                    ofin_next   = auto_reg;
                    olvl_next   = lvl_wide[8:0];
                    open_next   = 1'b0;
                    status_next = pa_pkg::ST_ACCEPT;
                    fsm_next    = E_IDLE;
                end
            end
            default: begin
                fsm_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg    <= E_IDLE;
            auto_reg   <= 4'd0;
            height_reg <= HW'(1);
            status_reg <= pa_pkg::ST_ACCEPT;
            open_reg   <= 1'b0;
            pend_reg   <= 1'b0;
            oval_reg   <= 1'b0;
        end else begin
            fsm_reg    <= fsm_next;
            auto_reg   <= auto_next;
            height_reg <= height_next;
            status_reg <= status_next;
            open_reg   <= open_next;
            pend_reg   <= pend_next;
            oval_reg   <= oval_next;
        end
        top_reg    <= top_next;
        moves_reg  <= moves_next;
        ending_reg <= ending_next;
        cur_reg    <= cur_next;
        scan_reg   <= scan_next;
        ent_reg    <= ent_next;
        cnt_reg    <= cnt_next;
        k_reg      <= k_next;
        ostat_reg  <= ostat_next;
        ofin_reg   <= ofin_next;
        olvl_reg   <= olvl_next;
    end

    // Transition table
    always_ff @(posedge aclk) begin
        if (tab_we) begin
            table_mem[tab_waddr] <= q_item.entry;
        end
        if (tab_re) begin
            tab_q <= table_mem[tab_raddr];
        end
    end

    // Symbol stack
    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re) begin
            stk_q <= stack_mem[stk_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/pushdown_automaton_recognizer.sv
// ----------------------------------------------------------------------------
// pushdown_automaton_recognizer
// Table-driven pushdown automaton that recognizes words of input symbols.
// ----------------------------------------------------------------------------
// Usage: load transition entries with command 0 words on the s_ channel, then
// send data symbols (command 1, tlast on the final symbol) or command 2 for an
// empty word. One result word per recognized word appears on the m_ channel.
// The user must write configuration words on the cfg_ channel only while the
// block is idle; the block does not enforce it. cfg_ready is always high.
// Each move scans the table in order, one entry per cycle, and compares each
// entry once its registered read returns; the move then writes its pushed
// symbols one per cycle, or reloads the top from the stack when nothing is
// pushed and the stack is not left empty. The end of a word runs its remaining
// moves before the result is registered. The table memory has a single read
// port. Items are handled one at a time.
// Reset clears control state; the table and stack hold nothing valid until
// written, and no clearing pass runs. A two-word queue sits behind s_tready,
// and a result waiting on m_tready holds the engine only when the next
// result is due.
// ----------------------------------------------------------------------------
`default_nettype none

module pushdown_automaton_recognizer #(
    parameter int TABLE_ENTRIES = 64,
    parameter int STACK_DEPTH   = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // entry_index, from_state, read_symbol, read_epsilon, required stack top,
    // to_state, push_count, push_string, data_symbol, zero pad
    input  wire logic [47:0] s_tdata,
    // command
    input  wire logic [1:0]  s_tuser,
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status, final_state, stack_level
    output logic [15:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    pa_pkg::pa_cfg_t   cfg_reg, cfg_next;
    logic [15:0]       allowed_reg, allowed_next;
    pa_pkg::pa_entry_t in_entry;
    logic              q_valid, q_ready;
    pa_pkg::pa_item_t  q_item;
    logic [2:0]        out_status;
    logic [3:0]        out_final_state;
    logic [8:0]        out_stack_level;

    assign cfg_ready = 1'b1;

    // Unpack the entry fields
    always_comb begin
        in_entry.from_state   = s_tdata[9:6];
        in_entry.read_symbol  = s_tdata[13:10];
        in_entry.read_epsilon = s_tdata[14];
        in_entry.need_top     = s_tdata[18:15];
        in_entry.to_state     = s_tdata[22:19];
        in_entry.push_count   = s_tdata[25:23];
        in_entry.push_string  = s_tdata[41:26];
    end

    // Decode configuration writes
    always_comb begin
        cfg_next     = cfg_reg;
        allowed_next = allowed_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                pa_pkg::CFG_START_STATE:  cfg_next.start_state        = cfg_data[3:0];
                pa_pkg::CFG_START_SYMBOL: cfg_next.start_stack_symbol = cfg_data[3:0];
                pa_pkg::CFG_ACCEPT:       cfg_next.accept_states      = cfg_data;
                pa_pkg::CFG_ALLOWED:      allowed_next                = cfg_data;
                pa_pkg::CFG_ENTRY_COUNT:  cfg_next.entry_count        = cfg_data[6:0];
                pa_pkg::CFG_MOVE_LIMIT:   cfg_next.move_limit         = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_state        <= 4'd0;
            cfg_reg.start_stack_symbol <= 4'd0;
            cfg_reg.accept_states      <= 16'd0;
            cfg_reg.entry_count        <= 7'd0;
            cfg_reg.move_limit         <= 16'd1024;
            allowed_reg                <= 16'hFFFF;
        end else begin
            cfg_reg     <= cfg_next;
            allowed_reg <= allowed_next;
        end
    end

    pa_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_command     (s_tuser),
        .in_entry       (in_entry),
        .in_entry_index (s_tdata[5:0]),
        .in_data_symbol (s_tdata[45:42]),
        .in_last        (s_tlast),
        .symbol_allowed (allowed_reg),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_item         (q_item)
    );

    pa_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .STACK_DEPTH   (STACK_DEPTH)
    ) u_engine (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_item          (q_item),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_status      (out_status),
        .out_final_state (out_final_state),
        .out_stack_level (out_stack_level)
    );

    assign m_tdata = {out_stack_level, out_final_state, out_status};

endmodule

`default_nettype wire

### rtl/pa_checker.sv
// ----------------------------------------------------------------------------
// pa_checker
// Port-level checks of the pushdown automaton recognizer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module pa_checker #(
    parameter int STACK_DEPTH = 256
) (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        cfg_ready
);

    // Hold a stalled result word
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // No result straight out of reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Input side ready straight out of reset, with the queue empty
    a_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

    // Status is one of the defined codes
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] == pa_pkg::ST_ACCEPT) || (m_tdata[2:0] == pa_pkg::ST_REJECT) ||
                     (m_tdata[2:0] == pa_pkg::ST_ILLEGAL) ||
                     (m_tdata[2:0] == pa_pkg::ST_OVERFLOW) ||
                     (m_tdata[2:0] == pa_pkg::ST_LIMIT))
        else $error("undefined status code");

    // Reported stack level never exceeds the stack depth
    a_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && cfg_ready |-> (32'(m_tdata[15:7]) <= STACK_DEPTH))
        else $error("stack level beyond depth");

endmodule

bind pushdown_automaton_recognizer pa_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_pa_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_ready (cfg_ready)
);

`default_nettype wire

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the pushdown automaton recogniser on the stream and config channels.
// Directed words exercise balanced strings, empty stack, illegal symbols,
// overflow, move limit and register extremes. Random tables then drive random
// words. An in-bench automaton predicts each result word.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [2:0] status;
        logic [3:0] final_state;
        logic [8:0] level;
    } verdict_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = pa_pkg::CMD_NOP;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = pa_pkg::CFG_START_STATE;
    logic [15:0] cfg_data = '0;

    pushdown_automaton_recognizer i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Automaton copy kept by the bench
    pa_pkg::pa_entry_t rules [64];
    logic [3:0] pstack [256];
    int         height = 1;
    logic [3:0] pstate = '0;
    logic [2:0] wstatus = pa_pkg::ST_ACCEPT;
    bit         open_flag = 0;
    logic [3:0]  c_start = '0, c_bottom = '0;
    logic [15:0] c_accept = '0, c_allowed = 16'hFFFF, c_limit = 16'd1024;
    logic [6:0]  c_count = '0;

    verdict_t pending_verdicts [$];
    int errors = 0;
    int words_seen = 0;
    int status_seen [5] = '{0, 0, 0, 0, 0};
    bit quiet = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result stall: random, except in quiet stretches
    always @(negedge aclk) m_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 34);

    task automatic report(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Compare each result word with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                report("unexpected result word", m_tdata, 0);
            end else begin
                verdict_t v;
                v = pending_verdicts.pop_front();
                if (m_tdata[2:0] !== v.status) report("status", m_tdata[2:0], v.status);
                if (m_tdata[6:3] !== v.final_state)
                    report("final_state", m_tdata[6:3], v.final_state);
                if (m_tdata[15:7] !== v.level) report("stack_level", m_tdata[15:7], v.level);
                words_seen++;
                if (v.status <= pa_pkg::ST_LIMIT) status_seen[v.status]++;
            end
        end
    end

    // ---------------- automaton prediction ----------------
    function automatic int match_rule(input logic [3:0] sym, input bit reading);
        int n;
        logic [3:0] top;
        n = (c_count > 64) ? 64 : int'(c_count);
        top = pstack[height - 1];
        for (int j = 0; j < n; j++) begin
            if (rules[j].from_state != pstate || rules[j].need_top != top) continue;
            if (rules[j].read_epsilon) return j;
            if (reading && rules[j].read_symbol == sym) return j;
        end
        return -1;
    endfunction

    function automatic bit apply_rule(input int j);
        int cnt;
        cnt = (rules[j].push_count > 4) ? 4 : int'(rules[j].push_count);
        if (height - 1 + cnt > 256) begin
            wstatus = pa_pkg::ST_OVERFLOW;
            return 0;
        end
        height--;
        for (int k = cnt; k > 0; k--) begin
            pstack[height] = rules[j].push_string[4*(k-1) +: 4];
            height++;
        end
        pstate = rules[j].to_state;
        return 1;
    endfunction

    function automatic void consume_symbol(input logic [3:0] sym);
        int moves, j;
        int lim;
        moves = 0;
        lim = (c_limit == 0) ? 1 : int'(c_limit);
        forever begin
            if (height == 0) begin
                wstatus = pa_pkg::ST_REJECT;
                return;
            end
            j = match_rule(sym, 1);
            if (j < 0) begin
                wstatus = pa_pkg::ST_REJECT;
                return;
            end
            if (moves >= lim) begin
                wstatus = pa_pkg::ST_LIMIT;
                return;
            end
            if (!apply_rule(j)) return;
            moves++;
            if (!rules[j].read_epsilon) return;
        end
    endfunction

    function automatic void drain_epsilon();
        int moves, j;
        int lim;
        moves = 0;
        lim = (c_limit == 0) ? 1 : int'(c_limit);
        forever begin
            if (height == 0) return;
            j = match_rule('0, 0);
            if (j < 0) return;
            if (moves >= lim) begin
                wstatus = pa_pkg::ST_LIMIT;
                return;
            end
            if (!apply_rule(j)) return;
            moves++;
        end
    endfunction

    function automatic void begin_word();
        if (open_flag) return;
        open_flag = 1;
        pstate = c_start;
        pstack[0] = c_bottom;
        height = 1;
        wstatus = pa_pkg::ST_ACCEPT;
    endfunction

    function automatic void close_word();
        verdict_t v;
        if (wstatus == pa_pkg::ST_ACCEPT) begin
            drain_epsilon();
            if (wstatus == pa_pkg::ST_ACCEPT)
                wstatus = c_accept[pstate] ? pa_pkg::ST_ACCEPT : pa_pkg::ST_REJECT;
        end
        v.status = wstatus;
        v.final_state = pstate;
        v.level = 9'(height);
        pending_verdicts = {pending_verdicts, v};
        open_flag = 0;
        wstatus = pa_pkg::ST_ACCEPT;
    endfunction

    function automatic void predict_word(input logic [1:0] cmd, input logic [47:0] d,
                                         input logic last);
        pa_pkg::pa_entry_t e;
        logic [3:0] sym;
        case (cmd)
            pa_pkg::CMD_LOAD: begin
                e.from_state = d[9:6];
                e.read_symbol = d[13:10];
                e.read_epsilon = d[14];
                e.need_top = d[18:15];
                e.to_state = d[22:19];
                e.push_count = d[25:23];
                e.push_string = d[41:26];
                rules[d[5:0]] = e;
            end
            pa_pkg::CMD_SYM: begin
                sym = d[45:42];
                begin_word();
                if (!c_allowed[sym]) wstatus = pa_pkg::ST_ILLEGAL;
                else if (wstatus == pa_pkg::ST_ACCEPT) consume_symbol(sym);
                if (last) close_word();
            end
            pa_pkg::CMD_END: begin
                begin_word();
                close_word();
            end
            default: ;
        endcase
    endfunction

    // ---------------- drivers ----------------
    task automatic send_word(input logic [1:0] cmd, input logic [47:0] d, input logic last);
        if (!quiet && $urandom_range(0, 99) < 34) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tuser = cmd;
        s_tdata = d;
        s_tlast = last;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_word(cmd, d, last);
        @(negedge aclk);
    endtask

    task automatic load_rule(input int idx, input logic [3:0] from, input logic [3:0] rd,
                             input logic eps, input logic [3:0] pop, input logic [3:0] to,
                             input logic [2:0] cnt, input logic [15:0] str);
        send_word(pa_pkg::CMD_LOAD, {6'd0, 4'd0, str, cnt, to, pop, eps, rd, from, 6'(idx)},
                  1'b0);
    endtask

    task automatic feed_symbol(input logic [3:0] sym, input logic last);
        send_word(pa_pkg::CMD_SYM, {2'd0, sym, 42'd0}, last);
    endtask

    task automatic end_word();
        send_word(pa_pkg::CMD_END, 48'd0, 1'b0);
    endtask

    task automatic feed_string(input logic [3:0] syms [$]);
        foreach (syms[i]) feed_symbol(syms[i], i == syms.size() - 1);
    endtask

    // Settle: every result in, then a pause for loads still in flight
    task automatic settle();
        s_tvalid = 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            pa_pkg::CFG_START_STATE:  c_start = val[3:0];
            pa_pkg::CFG_START_SYMBOL: c_bottom = val[3:0];
            pa_pkg::CFG_ACCEPT:       c_accept = val;
            pa_pkg::CFG_ALLOWED:      c_allowed = val;
            pa_pkg::CFG_ENTRY_COUNT:  c_count = val[6:0];
            pa_pkg::CFG_MOVE_LIMIT:   c_limit = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // ---------------- tests ----------------
    // Empty table after reset: every word falls through
    task automatic test_reset_state();
        end_word();
        feed_symbol(4'd5, 1'b1);
        send_word(pa_pkg::CMD_NOP, 48'hFFFF_FFFF_FFFF, 1'b1);
        settle();
    endtask

    // Fill every slot so no scan reads an unwritten entry
    task automatic test_table_fill();
        for (int i = 0; i < 64; i++)
            load_rule(i, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom);
        settle();
    endtask

    // Balanced a^n b^n, with the empty stack and no-match cases
    task automatic test_balanced();
        load_rule(0, 0, 0, 0, 0, 0, 2, 16'h0001);
        load_rule(1, 0, 0, 0, 1, 0, 2, 16'h0011);
        load_rule(2, 0, 1, 0, 1, 1, 0, 16'h0000);
        load_rule(3, 1, 1, 0, 1, 1, 0, 16'h0000);
        load_rule(4, 1, 0, 1, 0, 2, 0, 16'h0000);
        settle();
        write_reg(pa_pkg::CFG_START_STATE, 0);
        write_reg(pa_pkg::CFG_START_SYMBOL, 0);
        write_reg(pa_pkg::CFG_ACCEPT, 16'h0004);
        write_reg(pa_pkg::CFG_ENTRY_COUNT, 5);
        end_word();
        feed_string('{4'd0, 4'd1});
        feed_string('{4'd0, 4'd0, 4'd1, 4'd1});
        feed_string('{4'd0, 4'd0, 4'd1});
        feed_string('{4'd0, 4'd1, 4'd1});
        feed_string('{4'd1, 4'd0});
        settle();
        // Illegal symbol inside a word overrides the earlier rejection
        write_reg(pa_pkg::CFG_ALLOWED, 16'hFFF7);
        feed_string('{4'd1, 4'd3, 4'd0});
        settle();
        write_reg(pa_pkg::CFG_ALLOWED, 16'h0000);
        feed_string('{4'd0});
        settle();
        write_reg(pa_pkg::CFG_ALLOWED, 16'hFFFF);
        feed_string('{4'd0, 4'd1});
        settle();
    endtask

    // Stack growth up to overflow, with the clamped push length
    task automatic test_overflow();
        load_rule(0, 0, 0, 1, 0, 0, 7, 16'h0000);
        settle();
        write_reg(pa_pkg::CFG_ENTRY_COUNT, 1);
        write_reg(pa_pkg::CFG_MOVE_LIMIT, 16'hFFFF);
        feed_string('{4'd9});
        load_rule(0, 0, 0, 1, 0, 0, 2, 16'h0000);
        end_word();
        settle();
    endtask

    // Move limit on a looping epsilon entry, extreme start registers
    task automatic test_move_limit();
        load_rule(0, 15, 0, 1, 15, 15, 1, 16'h000F);
        settle();
        write_reg(pa_pkg::CFG_START_STATE, 15);
        write_reg(pa_pkg::CFG_START_SYMBOL, 15);
        write_reg(pa_pkg::CFG_ACCEPT, 16'hFFFF);
        write_reg(pa_pkg::CFG_MOVE_LIMIT, 1);
        feed_string('{4'd2, 4'd4});
        settle();
        write_reg(pa_pkg::CFG_MOVE_LIMIT, 3);
        end_word();
        settle();
        write_reg(pa_pkg::CFG_ENTRY_COUNT, 0);
        end_word();
        settle();
    endtask

    // Random table and words; well-formed words over a small alphabet mostly
    task automatic test_random_phase(input int n_items, input int max_count);
        int cnt, len;
        logic [3:0] sym;
        cnt = $urandom_range(1, max_count);
        for (int j = 0; j < cnt; j++)
            load_rule(j, $urandom_range(0, 3), $urandom_range(0, 3),
                      $urandom_range(0, 3) == 0, $urandom_range(0, 3), $urandom_range(0, 3),
                      ($urandom_range(0, 9) == 0) ? $urandom_range(3, 7) : $urandom_range(0, 2),
                      $urandom & 16'h3333 | ($urandom_range(0, 7) == 0 ? $urandom : 0));
        settle();
        write_reg(pa_pkg::CFG_START_STATE, $urandom_range(0, 3));
        write_reg(pa_pkg::CFG_START_SYMBOL, $urandom_range(0, 3));
        write_reg(pa_pkg::CFG_ACCEPT, $urandom);
        write_reg(pa_pkg::CFG_ALLOWED, ($urandom_range(0, 3) == 0) ? $urandom : 16'hFFFF);
        write_reg(pa_pkg::CFG_ENTRY_COUNT,
                  (max_count == 64) ? 7'($urandom_range(64, 127)) : cnt);
        write_reg(pa_pkg::CFG_MOVE_LIMIT, $urandom_range(1, 12));
        // The full-table phase always runs without any idling
        quiet = (max_count == 64) || ($urandom_range(0, 4) == 0);
        while (n_items > 0) begin
            case ($urandom_range(0, 19))
                0, 1: begin
                    end_word();
                    n_items--;
                end
                2: begin
                    send_word(pa_pkg::CMD_NOP, {$urandom, $urandom}, $urandom);
                end
                3: begin
                    load_rule($urandom_range(0, 63), $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom);
                    n_items--;
                end
                default: begin
                    len = $urandom_range(1, 6);
                    for (int k = 0; k < len; k++) begin
                        sym = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
                        feed_symbol(sym, k == len - 1);
                    end
                    n_items -= len;
                end
            endcase
        end
        settle();
        quiet = 0;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_reset_state();
        test_table_fill();
        test_balanced();
        test_overflow();
        test_move_limit();
        for (int p = 0; p < 8; p++) test_random_phase(200, (p == 3) ? 64 : 16);
        $display("Run covered %0d result words: %0d accepted, %0d rejected, %0d illegal,",
                 words_seen, status_seen[0], status_seen[1], status_seen[2]);
        $display("%0d overflow, %0d move limit, over directed and random tables.",
                 status_seen[3], status_seen[4]);
        if (errors == 0 && pending_verdicts.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #500ms;
        $display("testbench failed");
        $finish;
    end

endmodule

`default_nettype wire

### pushdown_automaton_recognizer.f
rtl/pa_pkg.sv
rtl/pa_front.sv
rtl/pa_engine.sv
rtl/pushdown_automaton_recognizer.sv
rtl/pa_checker.sv
tb/sv/testbench.sv
